// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros: shared concurrent assertion macros
// Clocked checks with an asynchronous active-low reset as the disable term.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

// condition must never be true at a rising edge outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");

`endif

// ===== hw/rtl/usc_pkg.sv =====
// ----------------------------------------------------------------------------
// usc_pkg: shared definitions for the unique ordered set
// Capacity, derived widths, command and status codes, state and cell types.
// ----------------------------------------------------------------------------
package usc_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_QUERY  = 2'd2,
		OP_DUMP   = 2'd3
	} usc_op_t;

	typedef enum logic [1:0] {
		STAT_OK     = 2'd0,
		STAT_DUP    = 2'd1,
		STAT_ABSENT = 2'd2,
		STAT_FULL   = 2'd3
	} usc_status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DUMP
	} usc_state_t;

	// controls broadcast to every cell of the chain
	typedef struct packed {
		logic        shift;
		logic        rotate;
		logic [31:0] key;
	} usc_cell_ctrl_t;

endpackage

// ===== hw/rtl/usc_if.sv =====
// ----------------------------------------------------------------------------
// usc_if: command and result channels of the unique ordered set
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface usc_cmd_if;
	logic               valid;
	logic               ready;
	logic        [1:0]  opcode;
	logic signed [31:0] value;

	modport source (output valid, output opcode, output value, input ready);
	modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface usc_res_if;
	logic               valid;
	logic               ready;
	logic        [1:0]  status;
	logic               found;
	logic signed [31:0] entry_value;
	logic               entry_present;
	logic               last;

	modport source (output valid, output status, output found, output entry_value,
		output entry_present, output last, input ready);
	modport sink   (input valid, input status, input found, input entry_value,
		input entry_present, input last, output ready);
endinterface

// ===== hw/rtl/usc_cell.sv =====
// ----------------------------------------------------------------------------
// usc_cell: one storage cell of the set chain
// Holds one entry, compares it with the broadcast key, passes the hit flag
// to the younger neighbor and takes its younger neighbor's entry on rotate, or on shift at or after a hit.
// ----------------------------------------------------------------------------
module usc_cell import usc_pkg::*; (
	input  logic           clk,
	input  usc_cell_ctrl_t ctl,
	input  logic           occupied,
	input  logic           load,
	input  logic           hit_in,
	input  logic [31:0]    nxt_data,
	output logic [31:0]    data,
	output logic           hit_out
);

	logic [31:0] data_q;

	// hit seen at this cell or any older one
	assign hit_out = hit_in | (occupied & (data_q == ctl.key));
	assign data    = data_q;

	// entry register: append, close a gap, or rotate for a dump
	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= ctl.key;
		end else if (ctl.rotate || (ctl.shift && hit_out)) begin
			data_q <= nxt_data;
		end
	end

endmodule

// ===== hw/rtl/unique_ordered_set.sv =====
// ----------------------------------------------------------------------------
// unique_ordered_set: bounded insertion-ordered set of distinct 32-bit values
// Commands enter on cmd (opcode, value); results leave on res.
// ----------------------------------------------------------------------------
// Usage:
//   cmd takes one word at a time: add, remove, query or dump. ready is high
//   only while no command is being worked on.
//   add, remove and query give one result word; the result is registered
//   in the EXEC state once the result register is free, and the next
//   command can be taken when the set is back in IDLE.
//   Entries live in a chain of CAPACITY cells that compare in parallel;
//   remove closes the gap by shifting younger cells down.
//   dump rotates the whole chain once, reading cell 0 at each step: one
//   result per entry, oldest first, last marked; an empty set gives a
//   single result without an entry.
//   When res stalls, the result register holds its word and the chain waits.
//   Reset empties the set (count to zero) and drops any pending result;
//   entry storage is not cleared.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module unique_ordered_set import usc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	usc_cmd_if.sink   cmd,
	usc_res_if.source res
);

	usc_state_t      state_q, state_d;
	logic [1:0]      op_q;
	logic [31:0]     key_q;
	logic [CNT_W-1:0] count_q, count_d;
	logic [IDX_W-1:0] step_q, step_d;

	logic              out_valid_q, out_valid_d;
	logic [1:0]        out_status_q, out_status_d;
	logic              out_found_q, out_found_d;
	logic [31:0]       out_entry_q, out_entry_d;
	logic              out_present_q, out_present_d;
	logic              out_last_q, out_last_d;
	logic              out_load;

	usc_cell_ctrl_t    ctl;
	logic [31:0]       cell_data [CAPACITY];
	logic [CAPACITY:0] hit_chain;
	logic              any_hit;
	logic              out_free;
	logic              exec_fire;
	logic              is_full;
	logic              add_ok;
	logic              emit_now;
	logic              dump_last;

	// cell chain
	assign hit_chain[0] = 1'b0;
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic occ;
		logic ld;
		assign occ = (CNT_W'(i) < count_q);
		assign ld  = add_ok && (count_q == CNT_W'(i));
		usc_cell u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.occupied (occ),
			.load     (ld),
			.hit_in   (hit_chain[i]),
			.nxt_data (cell_data[(i + 1) % CAPACITY]),
			.data     (cell_data[i]),
			.hit_out  (hit_chain[i + 1])
		);
	end

	assign any_hit   = hit_chain[CAPACITY];
	assign out_free  = !out_valid_q || res.ready;
	assign exec_fire = (state_q == ST_EXEC) && out_free;
	assign is_full   = (count_q == CNT_W'(CAPACITY));
	assign add_ok    = exec_fire && (op_q == OP_ADD) && !any_hit && !is_full;

	// dump sequencing: emit while the step is below the fill count, or at step 0 when the set is empty
	assign emit_now  = (count_q == '0) ? (step_q == '0) : ({1'b0, step_q} < count_q);
	assign dump_last = (count_q == '0) || (({1'b0, step_q} + CNT_W'(1)) == count_q);

	// broadcast controls
	always_comb begin
		ctl.key    = key_q;
		ctl.shift  = exec_fire && (op_q == OP_REMOVE);
		ctl.rotate = (state_q == ST_DUMP) && (!emit_now || out_free);
	end

	// next state, count and result word
	always_comb begin
		state_d       = state_q;
		count_d       = count_q;
		step_d        = step_q;
		out_load      = 1'b0;
		out_status_d  = STAT_OK;
		out_found_d   = 1'b0;
		out_entry_d   = '0;
		out_present_d = 1'b0;
		out_last_d    = 1'b1;
		case (state_q)
			ST_IDLE: begin
				if (cmd.valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (op_q == OP_DUMP) begin
					state_d = ST_DUMP;
					step_d  = '0;
				end else if (out_free) begin
					state_d  = ST_IDLE;
					out_load = 1'b1;
					case (op_q)
						OP_ADD: begin
							if (any_hit) begin
								out_status_d = STAT_DUP;
							end else if (is_full) begin
								out_status_d = STAT_FULL;
							end else begin
								count_d = count_q + CNT_W'(1);
							end
						end
						OP_REMOVE: begin
							if (any_hit) begin
								count_d = count_q - CNT_W'(1);
							end else begin
								out_status_d = STAT_ABSENT;
							end
						end
						OP_QUERY: begin
							out_found_d = any_hit;
						end
						default: begin
							out_status_d = STAT_OK;
						end
					endcase
				end
			end
			ST_DUMP: begin
				if (emit_now && out_free) begin
					out_load      = 1'b1;
					out_present_d = (count_q != '0);
					out_entry_d   = (count_q != '0) ? cell_data[0] : '0;
					out_last_d    = dump_last;
				end
				if (ctl.rotate) begin
					step_d = step_q + IDX_W'(1);
					if (step_q == IDX_W'(CAPACITY - 1)) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid_d = out_load || (out_valid_q && !res.ready);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			step_q      <= step_d;
			out_valid_q <= out_valid_d;
		end
	end

	// command and result payload registers
	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			op_q  <= cmd.opcode;
			key_q <= cmd.value;
		end
		if (out_load) begin
			out_status_q  <= out_status_d;
			out_found_q   <= out_found_d;
			out_entry_q   <= out_entry_d;
			out_present_q <= out_present_d;
			out_last_q    <= out_last_d;
		end
	end

	// ports
	assign cmd.ready         = (state_q == ST_IDLE);
	assign res.valid         = out_valid_q;
	assign res.status        = out_status_q;
	assign res.found         = out_found_q;
	assign res.entry_value   = out_entry_q;
	assign res.entry_present = out_present_q;
	assign res.last          = out_last_q;

	// checks
	`ASSERT_NEVER(a_count_bound, clk, arst_n, count_q > CNT_W'(CAPACITY))
	`ASSERT_CLK(a_accept_exec, clk, arst_n, (cmd.valid && cmd.ready) |=> (state_q == ST_EXEC))
	`ASSERT_CLK(a_absent_last, clk, arst_n, (res.valid && !res.entry_present) |-> res.last)
	`ASSERT_CLK(a_found_query, clk, arst_n, (res.valid && res.found) |-> (res.status == STAT_OK))

endmodule

// ===== test/tb_unique_ordered_set.sv =====
// ----------------------------------------------------------------------------
// tb_unique_ordered_set: self-checking bench for the unique ordered set
// A directed table walks empty, extreme, duplicate, full and removal cases,
// then phases of random commands fill, churn and drain the set. A shadow
// copy of the set predicts every result word; both channels idle at random.
// ----------------------------------------------------------------------------
module tb_unique_ordered_set import usc_pkg::*; ();

	localparam int RANDOM_WORDS = 390;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int POOL_SIZE    = 24;
	localparam int DRAIN_CYCLES = 40;

	// one result word as the set should emit it
	typedef struct packed {
		usc_status_t status;
		logic        found;
		logic [31:0] entry_value;
		logic        entry_present;
		logic        last;
	} set_word_t;

	// fixed answer carried along with a directed command
	typedef struct packed {
		logic        typed;
		usc_status_t status;
		logic        found;
	} fixed_answer_t;

	typedef struct packed {
		usc_op_t       op;
		logic [31:0]   value;
		logic [4:0]    reps;
		fixed_answer_t answer;
	} probe_row_t;

	logic clk;
	logic arst_n;

	usc_cmd_if cmd_bus ();
	usc_res_if res_bus ();

	unique_ordered_set i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_bus),
		.res    (res_bus)
	);

	// shadow of the set contents
	logic [31:0] set_vals [CAPACITY];
	int          set_count;

	set_word_t     predicted [$];
	set_word_t     expected_words [$];
	fixed_answer_t sent_answers [$];

	probe_row_t  probe_table [17];
	logic [31:0] value_pool [POOL_SIZE];
	bit          idle_on;
	int          mismatch_count;
	int          cycle_count;

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	task automatic report_mismatch(input string what);
		mismatch_count++;
		$display("mismatch at cycle %0d: %s", cycle_count, what);
	endtask

	// works out the result words of one command and updates the shadow set
	function automatic void predict_command(input usc_op_t op, input logic [31:0] v);
		int        slot;
		bit        emitted;
		set_word_t w;
		slot    = -1;
		emitted = 1'b0;
		for (int i = 0; i < set_count; i++) begin
			if (slot < 0 && set_vals[i] == v)
				slot = i;
		end
		w = '{status: STAT_OK, found: 1'b0, entry_value: 32'd0, entry_present: 1'b0,
			last: 1'b1};
		case (op)
			OP_ADD: begin
				// duplicate check wins over full
				if (slot >= 0)
					w.status = STAT_DUP;
				else if (set_count >= CAPACITY)
					w.status = STAT_FULL;
				else begin
					set_vals[set_count] = v;
					set_count++;
				end
			end
			OP_REMOVE: begin
				if (slot < 0)
					w.status = STAT_ABSENT;
				else begin
					// close the gap, keeping order
					for (int i = slot; i + 1 < set_count; i++)
						set_vals[i] = set_vals[i + 1];
					set_count--;
				end
			end
			OP_QUERY: begin
				w.found = (slot >= 0);
			end
			default: begin
				// oldest first, last word marked
				for (int i = 0; i < set_count; i++) begin
					w.entry_value   = set_vals[i];
					w.entry_present = 1'b1;
					w.last          = (i + 1 == set_count);
					predicted.insert(predicted.size(), w);
					emitted = 1'b1;
				end
			end
		endcase
		if (!emitted)
			predicted.insert(predicted.size(), w);
	endfunction

	// sends one command word after a random gap
	task automatic drive_word(input usc_op_t op, input logic [31:0] v,
		input fixed_answer_t answer);
		int gap;
		gap = idle_on ? $urandom_range(0, 16) : 0;
		if (gap > 0) begin
			cmd_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sent_answers.insert(sent_answers.size(), answer);
		cmd_bus.valid  <= 1'b1;
		cmd_bus.opcode <= op;
		cmd_bus.value  <= v;
		do @(posedge clk); while (!cmd_bus.ready);
	endtask

	// watchdog
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words still expected", cycle_count,
				expected_words.size());
			$display("** unique_ordered_set: FAILED **");
			$finish;
		end
	end

	// switch idling on and off so that stretches run back to back
	initial begin
		idle_on = 1'b1;
		forever begin
			repeat ($urandom_range(150, 600)) @(posedge clk);
			idle_on <= ~idle_on;
		end
	end

	// result side: random stall before each word
	initial begin
		int stall;
		res_bus.ready <= 1'b0;
		while (arst_n !== 1'b1) @(posedge clk);
		forever begin
			stall = idle_on ? $urandom_range(0, 16) : 0;
			if (stall > 0) begin
				res_bus.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_bus.ready <= 1'b1;
			do @(posedge clk); while (res_bus.valid !== 1'b1);
		end
	end

	// accepted commands feed the predictor, accepted results are checked
	always @(posedge clk) begin : monitor
		fixed_answer_t answer;
		set_word_t     want;
		if (arst_n) begin
			if (cmd_bus.valid && cmd_bus.ready) begin
				answer = sent_answers.pop_front();
				predicted.delete();
				predict_command(usc_op_t'(cmd_bus.opcode), cmd_bus.value);
				if (answer.typed)
					expected_words.insert(expected_words.size(),
						'{answer.status, answer.found, 32'd0, 1'b0, 1'b1});
				else
					foreach (predicted[i])
						expected_words.insert(expected_words.size(), predicted[i]);
			end
			if (res_bus.valid && res_bus.ready) begin
				if (expected_words.size() == 0)
					report_mismatch($sformatf("unexpected word, entry_value %h",
						res_bus.entry_value));
				else begin
					want = expected_words.pop_front();
					if (res_bus.status !== want.status)
						report_mismatch($sformatf("status %0d, expected %0d",
							res_bus.status, want.status));
					if (res_bus.found !== want.found)
						report_mismatch($sformatf("found %b, expected %b",
							res_bus.found, want.found));
					if (res_bus.entry_value !== want.entry_value)
						report_mismatch($sformatf("entry_value %h, expected %h",
							res_bus.entry_value, want.entry_value));
					if (res_bus.entry_present !== want.entry_present)
						report_mismatch($sformatf("entry_present %b, expected %b",
							res_bus.entry_present, want.entry_present));
					if (res_bus.last !== want.last)
						report_mismatch($sformatf("last %b, expected %b",
							res_bus.last, want.last));
				end
			end
		end
	end

	// main sequence
	initial begin
		int          mode;
		int          pick;
		usc_op_t     op;
		logic [31:0] v;
		arst_n         <= 1'b0;
		cmd_bus.valid  <= 1'b0;
		cmd_bus.opcode <= OP_ADD;
		cmd_bus.value  <= 32'd0;
		mismatch_count = 0;
		set_count      = 0;

		// directed cases; typed answers where they are plain to see
		probe_table = '{
			'{OP_DUMP,   32'h0000_0000, 5'd1,  '{1'b1, STAT_OK,     1'b0}},
			'{OP_REMOVE, 32'h8000_0000, 5'd1,  '{1'b1, STAT_ABSENT, 1'b0}},
			'{OP_QUERY,  32'h7fff_ffff, 5'd1,  '{1'b1, STAT_OK,     1'b0}},
			'{OP_ADD,    32'h8000_0000, 5'd1,  '{1'b1, STAT_OK,     1'b0}},
			'{OP_ADD,    32'h7fff_ffff, 5'd1,  '{1'b1, STAT_OK,     1'b0}},
			'{OP_ADD,    32'hffff_ffff, 5'd1,  '{1'b1, STAT_OK,     1'b0}},
			'{OP_ADD,    32'h0000_0000, 5'd1,  '{1'b1, STAT_OK,     1'b0}},
			'{OP_QUERY,  32'h7fff_ffff, 5'd1,  '{1'b1, STAT_OK,     1'b1}},
			'{OP_REMOVE, 32'h7fff_ffff, 5'd1,  '{1'b1, STAT_OK,     1'b0}},
			'{OP_DUMP,   32'hffff_ffff, 5'd1,  '{1'b0, STAT_OK,     1'b0}},
			'{OP_ADD,    32'h5555_5550, 5'd13, '{1'b1, STAT_OK,     1'b0}},
			'{OP_ADD,    32'h1234_5678, 5'd1,  '{1'b1, STAT_FULL,   1'b0}},
			'{OP_ADD,    32'h8000_0000, 5'd1,  '{1'b1, STAT_DUP,    1'b0}},
			'{OP_DUMP,   32'h0000_0000, 5'd1,  '{1'b0, STAT_OK,     1'b0}},
			'{OP_REMOVE, 32'h8000_0000, 5'd1,  '{1'b1, STAT_OK,     1'b0}},
			'{OP_REMOVE, 32'h5555_555c, 5'd1,  '{1'b1, STAT_OK,     1'b0}},
			'{OP_DUMP,   32'h0000_0000, 5'd1,  '{1'b0, STAT_OK,     1'b0}}
		};

		// values mostly come from a small pool so that hits are common
		foreach (value_pool[i])
			value_pool[i] = $urandom;
		value_pool[0] = 32'h8000_0000;
		value_pool[1] = 32'h7fff_ffff;
		value_pool[2] = 32'hffff_ffff;
		value_pool[3] = 32'h0000_0000;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part
		foreach (probe_table[r])
			for (int k = 0; k < probe_table[r].reps; k++)
				drive_word(probe_table[r].op, probe_table[r].value + k,
					probe_table[r].answer);

		// random part: fill, drain and mixed phases
		mode = 0;
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n % 50 == 0)
				mode = $urandom_range(0, 2);
			pick = $urandom_range(0, 99);
			case (mode)
				0:       op = pick < 55 ? OP_ADD : pick < 70 ? OP_REMOVE :
					pick < 90 ? OP_QUERY : OP_DUMP;
				1:       op = pick < 15 ? OP_ADD : pick < 70 ? OP_REMOVE :
					pick < 90 ? OP_QUERY : OP_DUMP;
				default: op = pick < 35 ? OP_ADD : pick < 65 ? OP_REMOVE :
					pick < 90 ? OP_QUERY : OP_DUMP;
			endcase
			if ($urandom_range(0, 19) == 0)
				value_pool[$urandom_range(0, POOL_SIZE - 1)] = $urandom;
			v = ($urandom_range(0, 9) == 0) ? $urandom :
				value_pool[$urandom_range(0, POOL_SIZE - 1)];
			drive_word(op, v, '{1'b0, STAT_OK, 1'b0});
		end
		cmd_bus.valid <= 1'b0;

		// let the monitor log the last command, drain, then allow stray words
		@(posedge clk);
		while (expected_words.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("** unique_ordered_set: PASSED **");
		else
			$display("** unique_ordered_set: FAILED **");
		$finish;
	end

endmodule
